### rtl/core/depth_splat_zbuffer_core_macros.svh
// Assertion macros for the depth splat z-buffer core
`ifndef DEPTH_SPLAT_ZBUFFER_CORE_MACROS_SVH
`define DEPTH_SPLAT_ZBUFFER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define DSZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define DSZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dsz_pkg.sv
// Shared constants for the depth splat z-buffer core
package dsz_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 9;
  localparam int IDX_W      = 18;
  localparam int PIX_W      = 22;
  localparam int DIV_STEPS  = 64;
  localparam int IN_DATA_W  = 112;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SPLAT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 3'd6;

  localparam logic [31:0] FAR_DEPTH = 32'hFFFF_FFFF;
  localparam logic signed [63:0] PIX_LIMIT = 64'sd1048576;

endpackage

### rtl/core/dsz_ram.sv
// Generic single-port-write, registered-read RAM
module dsz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/depth_splat_zbuffer_core.sv
// Depth splat z-buffer core: top level with sequencer and shared arithmetic
//
// Input channel in_*: tuser carries the command (clear, splat, read), tdata the
// point and read index. One transaction on the output channel out_* answers
// each command: tdata the depth read (zero for other commands), tuser the
// near-clip drop flag. in_tready is high only while the core is idle; one
// command is processed at a time.
// Steps per command, from acceptance to result:
//   clear : width*height writes (one store write per cycle)
//   read  : registered store read, then the index range check
//   splat : projection of both axes, then up to 9 updated pixels; the bit-serial
//           divider takes 64 steps per axis and each pixel is a read-modify-
//           write through the single store port; a near-clip drop skips all of it.
// The shared 32x32 multiplier forms the projection products, the clear size
// and the row offset of every pixel.
// Reset returns the sequencer to idle, empties the output register and loads
// the register defaults; store contents are undefined until a clear.
// A stalled receiver holds the result in the output register; a finished
// command then waits until the register is free before the core goes idle.
module depth_splat_zbuffer_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // point_x, point_y, point_z, read_index
  input  logic [dsz_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // depth_value
  output logic [31:0]                    out_tdata,
  // status
  output logic [0:0]                     out_tuser,
  input  logic                           cfg_we,
  input  logic [dsz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsz_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  `include "depth_splat_zbuffer_core_macros.svh"

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (STORE > 1) ? $clog2(STORE) : 1;
  localparam logic [32:0] STORE_SIZE = 33'(STORE);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLR_MUL  = 5'd1;
  localparam logic [4:0] S_CLR      = 5'd2;
  localparam logic [4:0] S_PMUL     = 5'd3;
  localparam logic [4:0] S_DIV_INIT = 5'd4;
  localparam logic [4:0] S_DIV      = 5'd5;
  localparam logic [4:0] S_SIGN     = 5'd6;
  localparam logic [4:0] S_ADDC     = 5'd7;
  localparam logic [4:0] S_PIX      = 5'd8;
  localparam logic [4:0] S_WIN      = 5'd9;
  localparam logic [4:0] S_PIX_MUL  = 5'd10;
  localparam logic [4:0] S_PIX_ADDR = 5'd11;
  localparam logic [4:0] S_PIX_RD   = 5'd12;
  localparam logic [4:0] S_PIX_WR   = 5'd13;
  localparam logic [4:0] S_RD0      = 5'd14;
  localparam logic [4:0] S_RD1      = 5'd15;
  localparam logic [4:0] S_DONE     = 5'd16;

  logic [4:0]  state_r;
  logic [31:0] focal_x_r, focal_y_r, center_x_r, center_y_r, near_r;
  logic [dsz_pkg::DIM_W-1:0] width_r, height_r;

  logic [31:0] px_r, py_r, z_r;
  logic [15:0] ridx_r;
  logic        axis_r;
  logic signed [63:0] prod_r;
  logic [63:0] dvd_r;
  logic [31:0] rem_r;
  logic        neg_r;
  logic [dsz_pkg::IDX_W-1:0] cnt_r;
  logic signed [dsz_pkg::PIX_W-1:0] u_r, v_r;
  logic [dsz_pkg::DIM_W-1:0] xx_r, yy_r, x0_r, x1_r, y1_r;
  logic [AW-1:0] addr_r;
  logic [31:0] res_depth_r;
  logic        res_status_r;
  logic        out_valid_r;
  logic [31:0] out_depth_r;
  logic        out_status_r;

  logic [dsz_pkg::DIM_W-1:0] w_eff, h_eff;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic signed [63:0] s_adj, s_shift, pix_sat;
  logic signed [22:0] um1, up1, wm1, vm1, vp1, hm1, x0c, x1c, y0c, y1c;
  logic        win_empty;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0] ram_wdata, ram_rdata;
  logic        out_free;
  logic [1:0]  in_cmd;

  assign w_eff = (32'(width_r) > MAX_WIDTH) ? dsz_pkg::DIM_W'(MAX_WIDTH) : width_r;
  assign h_eff = (32'(height_r) > MAX_HEIGHT) ? dsz_pkg::DIM_W'(MAX_HEIGHT) : height_r;

  assign in_tready  = (state_r == S_IDLE);
  assign in_cmd     = in_tuser;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_depth_r;
  assign out_tuser  = out_status_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    unique case (state_r)
      S_PMUL: begin
        mul_a = $signed(axis_r ? focal_y_r : focal_x_r);
        mul_b = $signed(axis_r ? py_r : px_r);
      end
      S_CLR_MUL: begin
        mul_a = $signed({23'd0, w_eff});
        mul_b = $signed({23'd0, h_eff});
      end
      S_PIX_MUL: begin
        mul_a = $signed({23'd0, yy_r});
        mul_b = $signed({23'd0, w_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign rem_sh = {rem_r, dvd_r[63]};
  assign rem_ge = rem_sh >= {1'b0, z_r};

  assign s_adj   = prod_r[63] ? (prod_r + 64'sd65535) : prod_r;
  assign s_shift = s_adj >>> 16;
  assign pix_sat = (s_shift > dsz_pkg::PIX_LIMIT) ? dsz_pkg::PIX_LIMIT :
                   (s_shift < -dsz_pkg::PIX_LIMIT) ? -dsz_pkg::PIX_LIMIT : s_shift;

  always_comb begin
    um1 = {u_r[dsz_pkg::PIX_W-1], u_r} - 23'sd1;
    up1 = {u_r[dsz_pkg::PIX_W-1], u_r} + 23'sd1;
    vm1 = {v_r[dsz_pkg::PIX_W-1], v_r} - 23'sd1;
    vp1 = {v_r[dsz_pkg::PIX_W-1], v_r} + 23'sd1;
    wm1 = $signed({14'd0, w_eff}) - 23'sd1;
    hm1 = $signed({14'd0, h_eff}) - 23'sd1;
    x0c = (um1 > 23'sd0) ? um1 : 23'sd0;
    x1c = (up1 < wm1) ? up1 : wm1;
    y0c = (vm1 > 23'sd0) ? vm1 : 23'sd0;
    y1c = (vp1 < hm1) ? vp1 : hm1;
    win_empty = (x0c > x1c) || (y0c > y1c);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = z_r;
    if (state_r == S_CLR && cnt_r != prod_r[dsz_pkg::IDX_W-1:0]) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(cnt_r);
      ram_wdata = dsz_pkg::FAR_DEPTH;
    end else if (state_r == S_PIX_WR && z_r < ram_rdata) begin
      ram_we = 1'b1;
    end
  end

  dsz_ram #(
    .WIDTH (32),
    .DEPTH (STORE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      focal_x_r   <= 32'd32768000;
      focal_y_r   <= 32'd32768000;
      center_x_r  <= 32'd8388608;
      center_y_r  <= 32'd8388608;
      width_r     <= 9'd256;
      height_r    <= 9'd256;
      near_r      <= 32'd6554;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dsz_pkg::REG_FOCAL_X:  focal_x_r  <= cfg_wdata;
          dsz_pkg::REG_FOCAL_Y:  focal_y_r  <= cfg_wdata;
          dsz_pkg::REG_CENTER_X: center_x_r <= cfg_wdata;
          dsz_pkg::REG_CENTER_Y: center_y_r <= cfg_wdata;
          dsz_pkg::REG_WIDTH:    width_r    <= cfg_wdata[dsz_pkg::DIM_W-1:0];
          dsz_pkg::REG_HEIGHT:   height_r   <= cfg_wdata[dsz_pkg::DIM_W-1:0];
          dsz_pkg::REG_NEAR:     near_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            px_r         <= in_tdata[31:0];
            py_r         <= in_tdata[63:32];
            z_r          <= in_tdata[95:64];
            ridx_r       <= in_tdata[111:96];
            addr_r       <= AW'(in_tdata[111:96]);
            res_depth_r  <= '0;
            res_status_r <= 1'b0;
            axis_r       <= 1'b0;
            cnt_r        <= '0;
            unique case (in_cmd)
              dsz_pkg::CMD_CLEAR: state_r <= S_CLR_MUL;
              dsz_pkg::CMD_SPLAT: begin
                if (in_tdata[95:64] <= near_r) begin
                  res_status_r <= 1'b1;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_PMUL;
                end
              end
              dsz_pkg::CMD_READ: state_r <= S_RD0;
              default:           state_r <= S_DONE;
            endcase
          end
        end
        S_CLR_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_CLR;
        end
        S_CLR: begin
          if (cnt_r == prod_r[dsz_pkg::IDX_W-1:0]) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_PMUL: begin
          prod_r  <= mul_p;
          state_r <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          neg_r   <= prod_r[63];
          dvd_r   <= prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_ge ? 32'(rem_sh - {1'b0, z_r}) : rem_sh[31:0];
          dvd_r <= {dvd_r[62:0], rem_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[5:0] == 6'(dsz_pkg::DIV_STEPS - 1)) begin
            state_r <= S_SIGN;
          end
        end
        S_SIGN: begin
          prod_r  <= neg_r ? -$signed(dvd_r) : $signed(dvd_r);
          state_r <= S_ADDC;
        end
        S_ADDC: begin
          prod_r  <= prod_r + 64'($signed(axis_r ? center_y_r : center_x_r));
          state_r <= S_PIX;
        end
        S_PIX: begin
          if (axis_r) begin
            v_r     <= dsz_pkg::PIX_W'(pix_sat);
            state_r <= S_WIN;
          end else begin
            u_r     <= dsz_pkg::PIX_W'(pix_sat);
            axis_r  <= 1'b1;
            state_r <= S_PMUL;
          end
        end
        S_WIN: begin
          x0_r <= x0c[dsz_pkg::DIM_W-1:0];
          x1_r <= x1c[dsz_pkg::DIM_W-1:0];
          y1_r <= y1c[dsz_pkg::DIM_W-1:0];
          xx_r <= x0c[dsz_pkg::DIM_W-1:0];
          yy_r <= y0c[dsz_pkg::DIM_W-1:0];
          state_r <= win_empty ? S_DONE : S_PIX_MUL;
        end
        S_PIX_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_PIX_ADDR;
        end
        S_PIX_ADDR: begin
          addr_r  <= AW'(prod_r[dsz_pkg::IDX_W-1:0] + dsz_pkg::IDX_W'(xx_r));
          state_r <= S_PIX_RD;
        end
        S_PIX_RD: begin
          state_r <= S_PIX_WR;
        end
        S_PIX_WR: begin
          if (xx_r == x1_r) begin
            if (yy_r == y1_r) begin
              state_r <= S_DONE;
            end else begin
              yy_r    <= yy_r + 1'b1;
              xx_r    <= x0_r;
              state_r <= S_PIX_MUL;
            end
          end else begin
            xx_r    <= xx_r + 1'b1;
            state_r <= S_PIX_MUL;
          end
        end
        S_RD0: begin
          state_r <= S_RD1;
        end
        S_RD1: begin
          res_depth_r <= (33'(ridx_r) < STORE_SIZE) ? ram_rdata : dsz_pkg::FAR_DEPTH;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_depth_r  <= res_depth_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `DSZ_ASSERT_NXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r != S_IDLE,
    "accepted command left the sequencer idle")
  `DSZ_ASSERT_IMP(a_we_states, ram_we, (state_r == S_CLR) || (state_r == S_PIX_WR),
    "store written outside clear or pixel update")
  `DSZ_ASSERT_IMP(a_clear_bound, (state_r == S_CLR) && ram_we,
    cnt_r < prod_r[dsz_pkg::IDX_W-1:0], "clear wrote beyond the frame")
  `DSZ_ASSERT_IMP(a_div_rem, state_r == S_DIV, rem_r < z_r,
    "divider remainder not below divisor")
  `DSZ_ASSERT_IMP(a_win_bound, state_r == S_PIX_WR, (xx_r <= x1_r) && (yy_r <= y1_r),
    "pixel update outside its window")

endmodule

### dv/tb.sv
// Self-checking testbench for the depth splat z-buffer core
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int STALL_LIMIT = 400000;

  class zbuf_scoreboard;
    typedef struct packed {
      logic [31:0] depth;
      logic        status;
    } zres_t;

    logic [31:0] fx, fy, cx, cy, near;
    logic [8:0]  wreg, hreg;
    logic [31:0] depth_mem [65536];
    bit          seen [65536];
    int          extent;
    int          errors;
    zres_t       pending_q [$];

    function new();
      fx = 32'd32768000;
      fy = 32'd32768000;
      cx = 32'd8388608;
      cy = 32'd8388608;
      wreg = 9'd256;
      hreg = 9'd256;
      near = 32'd6554;
      extent = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [dsz_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        dsz_pkg::REG_FOCAL_X:  fx = d;
        dsz_pkg::REG_FOCAL_Y:  fy = d;
        dsz_pkg::REG_CENTER_X: cx = d;
        dsz_pkg::REG_CENTER_Y: cy = d;
        dsz_pkg::REG_WIDTH:    wreg = d[8:0];
        dsz_pkg::REG_HEIGHT:   hreg = d[8:0];
        dsz_pkg::REG_NEAR:     near = d;
        default: ;
      endcase
    endfunction

    function int width_eff();
      return (wreg > 256) ? 256 : int'(wreg);
    endfunction

    function int height_eff();
      return (hreg > 256) ? 256 : int'(hreg);
    endfunction

    function longint to_pixel(logic [31:0] f, logic [31:0] c, logic [31:0] ctr,
                              logic [31:0] z);
      longint p, q, s, pix;
      p = longint'($signed(f)) * longint'($signed(c));
      q = p / longint'({32'd0, z});
      s = q + longint'($signed(ctr));
      pix = s / 65536;
      if (pix > 1048576) pix = 1048576;
      if (pix < -1048576) pix = -1048576;
      return pix;
    endfunction

    function void note_input(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [15:0] ridx);
      zres_t  r;
      int     w, h, total, idx;
      longint u, v, x0, x1, y0, y1, yy, xx;
      r = '0;
      w = width_eff();
      h = height_eff();
      case (cmd)
        dsz_pkg::CMD_CLEAR: begin
          total = w * h;
          for (int i = 0; i < total; i++) begin
            depth_mem[i] = dsz_pkg::FAR_DEPTH;
            seen[i] = 1'b1;
          end
          if (total > extent) extent = total;
        end
        dsz_pkg::CMD_SPLAT: begin
          if (z <= near) begin
            r.status = 1'b1;
          end else begin
            u = to_pixel(fx, x, cx, z);
            v = to_pixel(fy, y, cy, z);
            x0 = (u - 1 > 0) ? u - 1 : 0;
            x1 = (u + 1 < w - 1) ? u + 1 : w - 1;
            y0 = (v - 1 > 0) ? v - 1 : 0;
            y1 = (v + 1 < h - 1) ? v + 1 : h - 1;
            for (yy = y0; yy <= y1; yy++)
              for (xx = x0; xx <= x1; xx++) begin
                idx = int'(yy * w + xx);
                if (idx < 65536 && seen[idx] && z < depth_mem[idx]) begin
                  depth_mem[idx] = z;
                end
              end
          end
        end
        dsz_pkg::CMD_READ: r.depth = depth_mem[ridx];
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] depth, logic status);
      zres_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result depth_value=%h status=%0d", depth, status);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (depth !== e.depth) begin
        $error("depth_value expected %h actual %h", e.depth, depth);
        errors++;
      end
      if (status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [dsz_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                     in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [31:0]                    out_tdata;
  logic [0:0]                     out_tuser;
  logic                           cfg_we;
  logic [dsz_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dsz_pkg::CFG_DATA_W-1:0] cfg_wdata;

  zbuf_scoreboard sb;
  bit             steady;
  int             stall_count;

  depth_splat_zbuffer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64],
                      in_tdata[111:96]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser[0]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z,
                           input logic [15:0] ridx);
    int gap;
    if (!steady && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {ridx, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] near);
    logic [31:0] vals [7];
    vals = '{fx, fy, cx, cy, w, h, near};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= dsz_pkg::CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      sb.write_reg(dsz_pkg::CFG_IDX_W'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] aim_coord(int t, logic [31:0] f, logic [31:0] c,
                                            logic [31:0] z);
    longint q, r;
    if (f == 32'd0) return $urandom;
    q = longint'(t) * 65536 + 32768 - longint'($signed(c));
    r = (q * longint'({32'd0, z})) / longint'($signed(f));
    return r[31:0];
  endfunction

  function automatic logic [31:0] pick_depth();
    longint zl;
    case ($urandom_range(9))
      0: return sb.near;
      1: return sb.near + 32'd1;
      2: return $urandom;
      default: begin
        zl = longint'(sb.near) + 1 + $urandom_range(0, 20 * 65536);
        return (zl > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : zl[31:0];
      end
    endcase
  endfunction

  task automatic rand_item();
    int          r, w, h;
    logic [31:0] z;
    logic [15:0] ridx;
    r = $urandom_range(99);
    w = sb.width_eff();
    h = sb.height_eff();
    if (r < 4 && w * h <= 4096) begin
      send_item(dsz_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, 16'($urandom));
    end else if (r < 7) begin
      send_item(CMD_NONE, $urandom, $urandom, $urandom, 16'($urandom));
    end else if (r < 32 && sb.extent > 0) begin
      ridx = 16'($urandom);
      if (!sb.seen[ridx]) ridx = 16'($urandom_range(0, sb.extent - 1));
      send_item(dsz_pkg::CMD_READ, $urandom, $urandom, $urandom, ridx);
    end else if (r < 85) begin
      z = pick_depth();
      send_item(dsz_pkg::CMD_SPLAT,
                aim_coord($urandom_range(0, w + 1) - 1, sb.fx, sb.cx, z),
                aim_coord($urandom_range(0, h + 1) - 1, sb.fy, sb.cy, z), z,
                16'($urandom));
    end else begin
      send_item(dsz_pkg::CMD_SPLAT, $urandom, $urandom, $urandom, 16'($urandom));
    end
  endtask

  task automatic run_phase(input logic [31:0] fx, input logic [31:0] fy,
                           input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] near, input int count);
    drain();
    write_regs(fx, fy, cx, cy, w, h, near);
    send_item(dsz_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, 16'($urandom));
    repeat (count) rand_item();
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = dsz_pkg::CMD_CLEAR;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    steady = 1'b0;
    stall_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_regs(32'd32768000, 32'd32768000, 32'd8388608, 32'd8388608, 32'd256,
               32'd256, 32'd6554);
    send_item(dsz_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'hFFFF);
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'h0000);
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'hFFFF);
    send_item(dsz_pkg::CMD_SPLAT, 32'd0, 32'd0, 32'h0001_0000, 16'd0);
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'(128 * 256 + 128));
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'(127 * 256 + 127));
    send_item(dsz_pkg::CMD_SPLAT, 32'd0, 32'd0, 32'd6554, 16'd0);
    send_item(dsz_pkg::CMD_SPLAT, 32'd0, 32'd0, 32'd0, 16'd0);
    send_item(dsz_pkg::CMD_SPLAT, 32'd0, 32'd0, 32'd6555, 16'd0);
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'(128 * 256 + 129));
    send_item(dsz_pkg::CMD_SPLAT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd6555, 16'd0);
    send_item(dsz_pkg::CMD_SPLAT, 32'h8000_0000, 32'h8000_0000, 32'd6555, 16'd0);
    send_item(dsz_pkg::CMD_SPLAT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'd0);
    send_item(dsz_pkg::CMD_SPLAT, aim_coord(0, sb.fx, sb.cx, 32'h0002_0000),
              aim_coord(0, sb.fy, sb.cy, 32'h0002_0000), 32'h0002_0000, 16'd0);
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'd0);
    send_item(dsz_pkg::CMD_SPLAT, aim_coord(255, sb.fx, sb.cx, 32'h0003_0000),
              aim_coord(255, sb.fy, sb.cy, 32'h0003_0000), 32'h0003_0000, 16'd0);
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'hFFFF);
    send_item(dsz_pkg::CMD_SPLAT, aim_coord(-1, sb.fx, sb.cx, 32'h0003_0000),
              aim_coord(-1, sb.fy, sb.cy, 32'h0003_0000), 32'h0001_8000, 16'd0);
    send_item(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'hAAAA);
    send_item(dsz_pkg::CMD_READ, 32'd0, 32'd0, 32'd0, 16'h5555);
    repeat (40) rand_item();

    run_phase(32'd32768000, 32'd32768000, 32'd8388608, 32'd8388608, 32'd16, 32'd12,
              32'd6554, 100);
    run_phase(32'd65536, 32'd65536, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0, 80);
    run_phase($urandom, $urandom, $urandom, $urandom, 32'd256, 32'd1, 32'd6554, 90);
    run_phase(32'd32768000, 32'hFCE0_0000, 32'd8388608, 32'd0, 32'd1, 32'd256,
              32'd100, 90);
    run_phase(32'hFF38_0000, 32'd19660800, 32'd524288, 32'd524288, 32'd20, 32'd20,
              32'd6554, 100);
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5,
              32'd7, 32'd0, 80);
    run_phase(32'd32768000, 32'd32768000, 32'd0, 32'd0, 32'd9, 32'd9,
              32'hFFFF_FFFF, 50);
    steady = 1'b1;
    run_phase(32'($urandom_range(1, 2000)) << 16, 32'($urandom_range(1, 2000)) << 16,
              32'($urandom_range(0, 32)) << 16, 32'($urandom_range(0, 32)) << 16,
              32'($urandom_range(1, 32)), 32'($urandom_range(1, 32)),
              32'($urandom_range(0, 65536)), 120);
    steady = 1'b0;
    repeat (3)
      run_phase($urandom, $urandom, 32'($urandom_range(0, 40)) << 16,
                32'($urandom_range(0, 40)) << 16, 32'($urandom_range(1, 40)),
                32'($urandom_range(1, 40)), 32'($urandom_range(0, 200000)), 100);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
